// ===== hdl/kvt_pkg.sv =====
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int RES_W   = 32;
  localparam int ENTRY_W = 5;
  localparam int CFG_W   = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } kvt_op_e;

  typedef struct packed {
    logic    vld;
    kvt_op_e op;
    logic    hit;
    logic    free_found;
  } kvt_tag_t;

endpackage

// ===== hdl/kvt_req_if.sv =====
`timescale 1ns / 1ps

interface kvt_req_if #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic signed [KEY_WIDTH-1:0]   key;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink (input valid, input op, input key, input value, output ready);
endinterface

// ===== hdl/kvt_rsp_if.sv =====
`timescale 1ns / 1ps

interface kvt_rsp_if;
  import kvt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [RES_W-1:0] result_value;
  logic [ENTRY_W-1:0]      entry_total;
  logic                    refused;

  modport source (output valid, output found, output result_value, output entry_total,
                  output refused, input ready);
  modport sink (input valid, input found, input result_value, input entry_total,
                input refused, output ready);
endinterface

// ===== hdl/kvt_cell.sv =====
`timescale 1ns / 1ps

module kvt_cell #(
  parameter int INDEX       = 0,
  parameter int IDX_W       = 4,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kvt_pkg::kvt_tag_t             tag_i,
  input  logic signed [KEY_WIDTH-1:0]   key_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic signed [VALUE_WIDTH-1:0] res_i,
  input  logic [IDX_W-1:0]              free_idx_i,
  input  logic                          ins_we_i,
  input  logic [IDX_W-1:0]              ins_idx_i,
  input  logic signed [KEY_WIDTH-1:0]   ins_key_i,
  input  logic signed [VALUE_WIDTH-1:0] ins_value_i,
  output kvt_pkg::kvt_tag_t             tag_o,
  output logic signed [KEY_WIDTH-1:0]   key_o,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic signed [VALUE_WIDTH-1:0] res_o,
  output logic [IDX_W-1:0]              free_idx_o
);
  import kvt_pkg::*;

  logic                          slot_vld_q, slot_vld_d;
  logic signed [KEY_WIDTH-1:0]   slot_key_q;
  logic signed [VALUE_WIDTH-1:0] slot_value_q;
  kvt_tag_t                      tag_q, tag_d;
  logic signed [KEY_WIDTH-1:0]   key_q;
  logic signed [VALUE_WIDTH-1:0] value_q;
  logic signed [VALUE_WIDTH-1:0] res_q, res_d;
  logic [IDX_W-1:0]              free_idx_q, free_idx_d;
  logic                          op_ok, match, is_free, ins_here;

  always_comb begin
    op_ok    = (tag_i.op == OP_ADD) || (tag_i.op == OP_SEARCH) || (tag_i.op == OP_REMOVE);
    match    = tag_i.vld && op_ok && !tag_i.hit && slot_vld_q && (slot_key_q == key_i);
    is_free  = tag_i.vld && !slot_vld_q && !tag_i.free_found;
    ins_here = ins_we_i && (ins_idx_i == IDX_W'(INDEX));

    tag_d      = tag_i;
    res_d      = res_i;
    free_idx_d = free_idx_i;
    if (match) begin
      tag_d.hit = 1'b1;
      res_d     = slot_value_q;
    end
    if (is_free) begin
      tag_d.free_found = 1'b1;
      free_idx_d       = IDX_W'(INDEX);
    end

    slot_vld_d = slot_vld_q;
    if (match && (tag_i.op == OP_REMOVE)) begin
      slot_vld_d = 1'b0;
    end
    if (ins_here) begin
      slot_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      tag_q      <= '0;
    end else begin
      slot_vld_q <= slot_vld_d;
      tag_q      <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_i;
    value_q    <= value_i;
    res_q      <= res_d;
    free_idx_q <= free_idx_d;
    if (ins_here) begin
      slot_key_q   <= ins_key_i;
      slot_value_q <= ins_value_i;
    end else if (match && (tag_i.op == OP_ADD)) begin
      slot_value_q <= value_i;
    end
  end

  assign tag_o      = tag_q;
  assign key_o      = key_q;
  assign value_o    = value_q;
  assign res_o      = res_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== hdl/key_value_table.sv =====
`timescale 1ns / 1ps

// Key-value table of CAPACITY entries with unique keys, organised as a row of
// slot cells. A request beat is passed from cell to cell, one cell per clock;
// each cell compares its key, updates or clears itself and notes the lowest
// free slot. Past the last cell the beat is held until the response register
// is free; then the result is settled, a new key is written into the free slot
// and the response beat is registered. A new request is accepted once the
// previous one has left the cell row and hold register, even while an earlier
// response still waits on rsp_o. The user must see that absent_value is written
// through cfg_we_i / cfg_wdata_i only while the table is idle; no logic here enforces it.
module key_value_table #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic signed [kvt_pkg::CFG_W-1:0]   cfg_wdata_i,
  kvt_req_if.sink                            req_i,
  kvt_rsp_if.source                          rsp_o
);
  import kvt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  kvt_tag_t                      tag   [CAPACITY+1];
  logic signed [KEY_WIDTH-1:0]   key   [CAPACITY+1];
  logic signed [VALUE_WIDTH-1:0] value [CAPACITY+1];
  logic signed [VALUE_WIDTH-1:0] res   [CAPACITY+1];
  logic [IDX_W-1:0]              fidx  [CAPACITY+1];

  logic signed [CFG_W-1:0]       absent_q;
  logic                          busy_q, busy_d;
  logic                          hold_vld_q, hold_vld_d;
  kvt_tag_t                      hold_tag_q;
  logic signed [KEY_WIDTH-1:0]   hold_key_q;
  logic signed [VALUE_WIDTH-1:0] hold_value_q;
  logic signed [VALUE_WIDTH-1:0] hold_res_q;
  logic [IDX_W-1:0]              hold_fidx_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          out_vld_q, out_vld_d;
  logic                          out_found_q, out_found_d;
  logic signed [RES_W-1:0]       out_res_q, out_res_d;
  logic [ENTRY_W-1:0]            out_total_q, out_total_d;
  logic                          out_refused_q, out_refused_d;
  logic                          accept, out_free, commit, ins_we;

  assign req_i.ready = !busy_q && !hold_vld_q;
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign commit      = hold_vld_q && out_free;

  assign tag[0]   = '{vld: accept, op: kvt_op_e'(req_i.op), hit: 1'b0, free_found: 1'b0};
  assign key[0]   = req_i.key;
  assign value[0] = req_i.value;
  assign res[0]   = '0;
  assign fidx[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvt_cell #(
      .INDEX      (i),
      .IDX_W      (IDX_W),
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tag_i      (tag[i]),
      .key_i      (key[i]),
      .value_i    (value[i]),
      .res_i      (res[i]),
      .free_idx_i (fidx[i]),
      .ins_we_i   (ins_we),
      .ins_idx_i  (hold_fidx_q),
      .ins_key_i  (hold_key_q),
      .ins_value_i(hold_value_q),
      .tag_o      (tag[i+1]),
      .key_o      (key[i+1]),
      .value_o    (value[i+1]),
      .res_o      (res[i+1]),
      .free_idx_o (fidx[i+1])
    );
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tag[CAPACITY].vld) begin
      busy_d = 1'b0;
    end

    hold_vld_d = hold_vld_q;
    if (tag[CAPACITY].vld) begin
      hold_vld_d = 1'b1;
    end else if (commit) begin
      hold_vld_d = 1'b0;
    end

    ins_we        = 1'b0;
    count_d       = count_q;
    out_found_d   = out_found_q;
    out_res_d     = out_res_q;
    out_total_d   = out_total_q;
    out_refused_d = out_refused_q;
    out_vld_d     = out_vld_q && !rsp_o.ready;

    if (commit) begin
      out_vld_d     = 1'b1;
      out_found_d   = hold_tag_q.hit;
      out_refused_d = 1'b0;
      out_res_d     = hold_tag_q.hit ? RES_W'($unsigned(hold_res_q)) : absent_q;
      case (hold_tag_q.op)
        OP_ADD: begin
          if (!hold_tag_q.hit) begin
            if (hold_tag_q.free_found) begin
              ins_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end else begin
              out_refused_d = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (hold_tag_q.hit && (count_q != '0)) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      out_total_d = ENTRY_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      absent_q   <= '0;
      busy_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        absent_q <= cfg_wdata_i;
      end
      busy_q     <= busy_d;
      hold_vld_q <= hold_vld_d;
      count_q    <= count_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag[CAPACITY].vld) begin
      hold_tag_q   <= tag[CAPACITY];
      hold_key_q   <= key[CAPACITY];
      hold_value_q <= value[CAPACITY];
      hold_res_q   <= res[CAPACITY];
      hold_fidx_q  <= fidx[CAPACITY];
    end
    out_found_q   <= out_found_d;
    out_res_q     <= out_res_d;
    out_total_q   <= out_total_d;
    out_refused_q <= out_refused_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.result_value = out_res_q;
  assign rsp_o.entry_total  = out_total_q;
  assign rsp_o.refused      = out_refused_q;

endmodule

// ===== tb/sv/kvt_tb_pkg.sv =====
`timescale 1ns / 1ps

package kvt_tb_pkg;
  import kvt_pkg::*;

  localparam int SLOTS = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic               found;
    logic [RES_W-1:0]   value;
    logic [ENTRY_W-1:0] total;
    logic               refused;
  } kvt_reply_t;

  class kvt_shadow_table;
    logic             used [SLOTS];
    logic [KEY_W-1:0] keys [SLOTS];
    logic [VAL_W-1:0] vals [SLOTS];
    int unsigned      live;
    logic [RES_W-1:0] absent;
    kvt_reply_t       awaited_replies [$];
    int unsigned      mismatches;
    int unsigned      replies;
    int unsigned      per_op [4];
    int unsigned      hits;
    int unsigned      refusals;
    int unsigned      full_seen;
    int unsigned      settings;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      foreach (per_op[i]) per_op[i] = 0;
      live       = 0;
      absent     = '0;
      mismatches = 0;
      replies    = 0;
      hits       = 0;
      refusals   = 0;
      full_seen  = 0;
      settings   = 1;
    endfunction

    function void set_absent(logic [RES_W-1:0] v);
      absent = v;
      settings++;
    endfunction

    function int unsigned outstanding();
      return awaited_replies.size();
    endfunction

    // works out the reply to one accepted request and updates the shadow table
    function void note_request(logic [1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      kvt_reply_t r;
      int         hit;
      int         free_slot;
      hit       = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i]) begin
          if (hit < 0 && keys[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      r.found   = 1'b0;
      r.value   = absent;
      r.refused = 1'b0;
      per_op[op]++;
      case (op)
        OP_ADD: begin
          if (hit >= 0) begin
            r.found   = 1'b1;
            r.value   = vals[hit];
            vals[hit] = value;
          end else if (free_slot >= 0) begin
            used[free_slot] = 1'b1;
            keys[free_slot] = key;
            vals[free_slot] = value;
            live++;
            if (live == SLOTS) full_seen++;
          end else begin
            r.refused = 1'b1;
            refusals++;
          end
        end
        OP_SEARCH: begin
          if (hit >= 0) begin
            r.found = 1'b1;
            r.value = vals[hit];
          end
        end
        OP_REMOVE: begin
          if (hit >= 0) begin
            r.found   = 1'b1;
            r.value   = vals[hit];
            used[hit] = 1'b0;
            if (live > 0) live--;
          end
        end
        default: ;
      endcase
      if (r.found) hits++;
      r.total = live[ENTRY_W-1:0];
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(kvt_reply_t got);
      kvt_reply_t want;
      replies++;
      if (awaited_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response beat: found=%0b value=%h total=%0d refused=%0b",
                   got.found, got.value, got.total, got.refused);
        mismatches++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.found !== want.found || got.value !== want.value ||
          got.total !== want.total || got.refused !== want.refused) begin
        if (mismatches < 10)
          $display("mismatch on reply %0d: expected found=%0b value=%h total=%0d refused=%0b, got found=%0b value=%h total=%0d refused=%0b",
                   replies, want.found, want.value, want.total, want.refused,
                   got.found, got.value, got.total, got.refused);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/key_value_table_tb.sv =====
`timescale 1ns / 1ps

module key_value_table_tb;
  import kvt_pkg::*;
  import kvt_tb_pkg::*;

  localparam int POOL        = 24;
  localparam int PHASE_ITEMS = 120;
  localparam int HOLD_CYCLES = 300;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic signed [CFG_W-1:0]  cfg_wdata_i;

  kvt_req_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W)) req ();
  kvt_rsp_if rsp ();

  key_value_table #(
    .CAPACITY    (SLOTS),
    .KEY_WIDTH   (KEY_W),
    .VALUE_WIDTH (VAL_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  kvt_shadow_table table_model = new();

  int unsigned      idle_pct = 24;
  bit               hold_off_req = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("timeout: %0d replies still awaited", table_model.outstanding());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // valid stays high across back-to-back beats; it is lowered only for a gap
  task automatic send_beat(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= key;
    req.value <= value;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    table_model.note_request(op, key, value);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (table_model.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_absent(input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    table_model.set_absent(v);
  endtask

  task automatic run_phase(input int add_w, input int search_w);
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    int               r;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 4 + add_w) op = OP_ADD;
      else if (r < 4 + add_w + search_w) op = OP_SEARCH;
      else op = OP_REMOVE;
      r = $urandom_range(99);
      if (r < 80) key = key_pool[$urandom_range(POOL - 1)];
      else if (r < 86) key = pick_extreme();
      else key = $urandom();
      value = ($urandom_range(15) == 0) ? pick_extreme() : $urandom();
      send_beat(op, key, value);
    end
    drain();
  endtask

  initial begin
    rsp.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready)
        table_model.check_reply('{found: rsp.found, value: rsp.result_value,
                                  total: rsp.entry_total, refused: rsp.refused});
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          rsp.ready <= 1'b0;
          @(posedge clk_i);
          if (rsp.valid && rsp.ready)
            table_model.check_reply('{found: rsp.found, value: rsp.result_value,
                                      total: rsp.entry_total, refused: rsp.refused});
        end
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    req.valid   = 1'b0;
    req.op      = OP_ADD;
    req.key     = '0;
    req.value   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misses on empty table under the reset marker, extreme keys,
    // overwrite, hit and miss removal, fill to capacity, refusal when full
    send_beat(OP_SEARCH, 32'h0000_0000, 32'h1111_1111);
    send_beat(OP_REMOVE, 32'h7fff_ffff, 32'h2222_2222);
    send_beat(OP_UNUSED, 32'hffff_ffff, 32'h3333_3333);
    send_beat(OP_ADD, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(OP_ADD, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(OP_ADD, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OP_ADD, 32'hffff_ffff, 32'h1234_5678);
    send_beat(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_beat(OP_REMOVE, 32'h0000_0000, 32'hffff_ffff);
    send_beat(OP_REMOVE, 32'h0000_0000, 32'hffff_ffff);
    send_beat(OP_UNUSED, 32'h7fff_ffff, 32'h0000_0000);
    for (int k = 0; k < SLOTS - 3; k++)
      send_beat(OP_ADD, 32'h0000_0100 + k, $urandom());
    send_beat(OP_ADD, 32'h5555_aaaa, 32'hdead_beef);
    send_beat(OP_ADD, 32'h7fff_ffff, 32'h0bad_cafe);
    drain();

    write_absent(32'h8000_0000);
    run_phase(60, 20);

    write_absent(32'h7fff_ffff);
    hold_off_req = 1'b1;
    run_phase(20, 26);

    write_absent(32'hffff_ffff);
    idle_pct = 0;
    run_phase(60, 16);
    idle_pct = 24;

    write_absent($urandom());
    run_phase(36, 30);

    write_absent(32'h0000_0000);
    run_phase(26, 30);

    repeat (SLOTS + 8) @(posedge clk_i);
    $display("covered %0d adds, %0d searches, %0d removes, %0d unused-op beats, %0d absent settings",
             table_model.per_op[OP_ADD], table_model.per_op[OP_SEARCH],
             table_model.per_op[OP_REMOVE], table_model.per_op[OP_UNUSED],
             table_model.settings);
    $display("%0d key hits, %0d refused adds, table filled %0d times, %0d replies checked",
             table_model.hits, table_model.refusals, table_model.full_seen,
             table_model.replies);
    if (table_model.outstanding() != 0)
      $display("%0d replies never arrived", table_model.outstanding());
    if (table_model.mismatches == 0 && table_model.outstanding() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
